### hw/rtl/ps2mpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared widths, register indexes and header bit positions for the PS/2
// mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int SIZE_BITS   = 13;
   localparam int CURSOR_BITS = 12;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [BYTE_BITS-1:0]      byte_type;
   typedef logic [SIZE_BITS-1:0]      size_type;
   typedef logic [CURSOR_BITS-1:0]    cursor_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_SCREEN_WIDTH  = 2'd0;
   localparam csr_index_type CSR_SCREEN_HEIGHT = 2'd1;
   localparam csr_index_type CSR_FOUR_BYTE     = 2'd2;

   localparam size_type WIDTH_RESET  = 13'd1024;
   localparam size_type HEIGHT_RESET = 13'd768;

   // header byte layout
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SYNC   = 3;
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;
   localparam int HDR_X_OVF  = 6;
   localparam int HDR_Y_OVF  = 7;

   typedef logic [1:0] byte_pos_type;
   localparam byte_pos_type POS_HEADER = 2'd0;
   localparam byte_pos_type POS_X      = 2'd1;
   localparam byte_pos_type POS_Y      = 2'd2;
   localparam byte_pos_type POS_EXTRA  = 2'd3;

endpackage

### hw/rtl/ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Collects PS/2 mouse bytes into packets, tracks a clamped cursor position
// and reports buttons and status once per completed packet.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the last byte of its packet is taken
// throughput: one byte per cycle, set by the single registered update of the
//   packet state and cursor position, but a packet's last byte stalls while a
//   result waits; the result register lets bytes that complete no packet pass
// reset: synchronous, clears byte position, stored bytes and cursor, screen
//   size returns to 1024 x 768 with three-byte packets
module ps2_mouse_packet_tracker #(
   parameter int POSITION_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  ps2mpt_pkg::csr_index_type  csr_index,
   input  ps2mpt_pkg::size_type       csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ps2mpt_pkg::byte_type       req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ps2mpt_pkg::cursor_type     rsp_cursor_x,
   output ps2mpt_pkg::cursor_type     rsp_cursor_y,
   output logic                       rsp_left_button,
   output logic                       rsp_middle_button,
   output logic                       rsp_right_button,
   output logic                       rsp_overflow_dropped,
   output logic                       rsp_sync_bit_missing
);
   import ps2mpt_pkg::*;

   localparam int SUM_BITS = POSITION_BITS + 2;
   localparam int CMP_BITS = (SUM_BITS > SIZE_BITS) ? SUM_BITS : SIZE_BITS;
   localparam int OUT_BITS = (POSITION_BITS > CURSOR_BITS) ? POSITION_BITS : CURSOR_BITS;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [CMP_BITS-1:0]      cmp_type;

   // configuration
   size_type width_ff, width_in;
   size_type height_ff, height_in;
   logic     four_byte_ff, four_byte_in;

   // packet state
   byte_pos_type byte_pos_ff, byte_pos_in;
   byte_type     header_ff, header_in;
   byte_type     x_byte_ff, x_byte_in;
   byte_type     y_byte_ff, y_byte_in;
   pos_type      pos_x_ff, pos_x_in;
   pos_type      pos_y_ff, pos_y_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   cursor_type cursor_x_ff, cursor_x_in;
   cursor_type cursor_y_ff, cursor_y_in;
   logic       left_ff, left_in;
   logic       middle_ff, middle_in;
   logic       right_ff, right_in;
   logic       ovf_ff, ovf_in;
   logic       sync_ff, sync_in;

   byte_pos_type     last_pos;
   logic             completes;
   logic             req_fire;
   logic             rsp_fire;
   byte_type         hdr;
   logic             ovf;
   logic signed [8:0] dx;
   logic signed [8:0] dy;
   logic signed [SUM_BITS-1:0] sum_x;
   logic signed [SUM_BITS-1:0] sum_y;
   pos_type          clamp_x;
   pos_type          clamp_y;

   function automatic cmp_type axis_limit(input size_type size);
      size_type lim;
      cmp_type  lim_max;
      cmp_type  lim_ext;
      begin
         lim     = (size == '0) ? '0 : size - size_type'(1);
         lim_max = CMP_BITS'({POSITION_BITS{1'b1}});
         lim_ext = CMP_BITS'(lim);
         axis_limit = (lim_ext > lim_max) ? lim_max : lim_ext;
      end
   endfunction

   function automatic pos_type clamp_axis(input logic signed [SUM_BITS-1:0] sum,
                                          input size_type size);
      cmp_type lim;
      cmp_type sum_ext;
      begin
         lim     = axis_limit(size);
         sum_ext = CMP_BITS'(sum);
         if (sum[SUM_BITS-1]) begin
            clamp_axis = '0;
         end else if (sum_ext > lim) begin
            clamp_axis = lim[POSITION_BITS-1:0];
         end else begin
            clamp_axis = sum[POSITION_BITS-1:0];
         end
      end
   endfunction

   assign last_pos  = four_byte_ff ? POS_EXTRA : POS_Y;
   assign completes = (byte_pos_ff >= last_pos);
   // a byte that finishes no packet never needs the result register
   assign req_ready = !completes || !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // the third byte of a three-byte packet is the y motion, use it directly
   always_comb begin
      hdr = header_ff;
      ovf = hdr[HDR_X_OVF] || hdr[HDR_Y_OVF];
      dx  = {hdr[HDR_X_SIGN], x_byte_ff};
      if (byte_pos_ff == POS_Y) begin
         dy = {hdr[HDR_Y_SIGN], req_rx_byte};
      end else begin
         dy = {hdr[HDR_Y_SIGN], y_byte_ff};
      end
      sum_x   = $signed({2'b00, pos_x_ff}) + SUM_BITS'(dx);
      sum_y   = $signed({2'b00, pos_y_ff}) - SUM_BITS'(dy);
      clamp_x = clamp_axis(sum_x, width_ff);
      clamp_y = clamp_axis(sum_y, height_ff);
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      four_byte_in = four_byte_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in     = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in    = csr_wdata;
            CSR_FOUR_BYTE:     four_byte_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      header_in    = header_ff;
      x_byte_in    = x_byte_ff;
      y_byte_in    = y_byte_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      left_in      = left_ff;
      middle_in    = middle_ff;
      right_in     = right_ff;
      ovf_in       = ovf_ff;
      sync_in      = sync_ff;
      if (req_fire) begin
         if (!completes) begin
            unique case (byte_pos_ff)
               POS_HEADER: header_in = req_rx_byte;
               POS_X:      x_byte_in = req_rx_byte;
               default:    y_byte_in = req_rx_byte;
            endcase
            byte_pos_in = byte_pos_ff + byte_pos_type'(1);
         end else begin
            if (byte_pos_ff == POS_Y) begin
               y_byte_in = req_rx_byte;
            end
            byte_pos_in = POS_HEADER;
            if (!ovf) begin
               pos_x_in = clamp_x;
               pos_y_in = clamp_y;
            end
            rsp_valid_in = 1'b1;
            cursor_x_in  = ovf ? cursor_type'(OUT_BITS'(pos_x_ff))
                               : cursor_type'(OUT_BITS'(clamp_x));
            cursor_y_in  = ovf ? cursor_type'(OUT_BITS'(pos_y_ff))
                               : cursor_type'(OUT_BITS'(clamp_y));
            left_in      = hdr[HDR_LEFT];
            middle_in    = hdr[HDR_MIDDLE];
            right_in     = hdr[HDR_RIGHT];
            ovf_in       = ovf;
            sync_in      = !hdr[HDR_SYNC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         four_byte_ff <= 1'b0;
         byte_pos_ff  <= POS_HEADER;
         header_ff    <= '0;
         x_byte_ff    <= '0;
         y_byte_ff    <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         four_byte_ff <= four_byte_in;
         byte_pos_ff  <= byte_pos_in;
         header_ff    <= header_in;
         x_byte_ff    <= x_byte_in;
         y_byte_ff    <= y_byte_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_x_ff <= cursor_x_in;
      cursor_y_ff <= cursor_y_in;
      left_ff     <= left_in;
      middle_ff   <= middle_in;
      right_ff    <= right_in;
      ovf_ff      <= ovf_in;
      sync_ff     <= sync_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cursor_x         = cursor_x_ff;
   assign rsp_cursor_y         = cursor_y_ff;
   assign rsp_left_button      = left_ff;
   assign rsp_middle_button    = middle_ff;
   assign rsp_right_button     = right_ff;
   assign rsp_overflow_dropped = ovf_ff;
   assign rsp_sync_bit_missing = sync_ff;

endmodule

### verif/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker
// Self-checking bench for the mouse packet tracker. It streams mouse bytes
// under random valid/ready gaps and predicts cursor, buttons and status for
// every packet, comparing each response field. Screen size and packet length
// change between phases, sometimes while a packet is half received.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;
   import ps2mpt_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_BYTES = 1725;
   localparam int CURSOR_MAX   = (1 << CURSOR_BITS) - 1;
   localparam int SIGN_WEIGHT  = 1 << BYTE_BITS;

   typedef struct {
      cursor_type cursor_x;
      cursor_type cursor_y;
      logic       left_button;
      logic       middle_button;
      logic       right_button;
      logic       overflow_dropped;
      logic       sync_bit_missing;
   } packet_report_type;

   class cursor_scoreboard;
      size_type          width_reg;
      size_type          height_reg;
      logic              four_byte_reg;
      byte_pos_type      slot;
      byte_type          header;
      byte_type          x_motion;
      byte_type          y_motion;
      cursor_type        pos_x;
      cursor_type        pos_y;
      packet_report_type expected_reports[$];
      int unsigned       errors;

      function new();
         width_reg     = WIDTH_RESET;
         height_reg    = HEIGHT_RESET;
         four_byte_reg = 1'b0;
         slot          = POS_HEADER;
         header        = '0;
         x_motion      = '0;
         y_motion      = '0;
         pos_x         = '0;
         pos_y         = '0;
         errors        = 0;
      endfunction

      function void write_reg(csr_index_type idx, size_type value);
         case (idx)
            CSR_SCREEN_WIDTH:  width_reg = value;
            CSR_SCREEN_HEIGHT: height_reg = value;
            CSR_FOUR_BYTE:     four_byte_reg = value[0];
            default: ;
         endcase
      endfunction

      // zero size acts as one; the limit saturates at the position range
      function cursor_type clamp_to_screen(int sum, size_type size);
         int limit;
         limit = (size == '0) ? 0 : int'(size) - 1;
         if (limit > CURSOR_MAX)
            limit = CURSOR_MAX;
         if (sum < 0)
            return '0;
         if (sum > limit)
            return cursor_type'(limit);
         return cursor_type'(sum);
      endfunction

      function void take_byte(byte_type value);
         byte_pos_type      last_slot;
         int                dx;
         int                dy;
         packet_report_type rep;
         last_slot = four_byte_reg ? POS_EXTRA : POS_Y;
         if (slot < last_slot) begin
            case (slot)
               POS_HEADER: header = value;
               POS_X:      x_motion = value;
               default:    y_motion = value;
            endcase
            slot = slot + 1'b1;
            return;
         end
         // a byte at or past the last slot closes the packet; at the y slot it is the y motion
         if (slot == POS_Y)
            y_motion = value;
         slot = POS_HEADER;
         rep.overflow_dropped = header[HDR_X_OVF] | header[HDR_Y_OVF];
         if (!rep.overflow_dropped) begin
            dx = header[HDR_X_SIGN] ? int'(x_motion) - SIGN_WEIGHT : int'(x_motion);
            dy = header[HDR_Y_SIGN] ? int'(y_motion) - SIGN_WEIGHT : int'(y_motion);
            pos_x = clamp_to_screen(int'(pos_x) + dx, width_reg);
            pos_y = clamp_to_screen(int'(pos_y) - dy, height_reg);
         end
         rep.cursor_x         = pos_x;
         rep.cursor_y         = pos_y;
         rep.left_button      = header[HDR_LEFT];
         rep.middle_button    = header[HDR_MIDDLE];
         rep.right_button     = header[HDR_RIGHT];
         rep.sync_bit_missing = ~header[HDR_SYNC];
         expected_reports.push_back(rep);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] ERROR %s", $time, what);
      endtask

      task compare_field(string name, logic [CURSOR_BITS-1:0] got,
                         logic [CURSOR_BITS-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s: got %0d, predicted %0d", name, got, want));
      endtask

      task check_packet_report(packet_report_type got);
         packet_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("response with no packet outstanding (x=%0d y=%0d)",
                                      got.cursor_x, got.cursor_y));
            return;
         end
         want = expected_reports.pop_front();
         compare_field("cursor_x", got.cursor_x, want.cursor_x);
         compare_field("cursor_y", got.cursor_y, want.cursor_y);
         compare_field("left_button", cursor_type'(got.left_button),
                       cursor_type'(want.left_button));
         compare_field("middle_button", cursor_type'(got.middle_button),
                       cursor_type'(want.middle_button));
         compare_field("right_button", cursor_type'(got.right_button),
                       cursor_type'(want.right_button));
         compare_field("overflow_dropped", cursor_type'(got.overflow_dropped),
                       cursor_type'(want.overflow_dropped));
         compare_field("sync_bit_missing", cursor_type'(got.sync_bit_missing),
                       cursor_type'(want.sync_bit_missing));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_SCREEN_WIDTH;
   size_type      csr_wdata = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   byte_type      req_rx_byte = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   cursor_type    rsp_cursor_x;
   cursor_type    rsp_cursor_y;
   logic          rsp_left_button;
   logic          rsp_middle_button;
   logic          rsp_right_button;
   logic          rsp_overflow_dropped;
   logic          rsp_sync_bit_missing;

   cursor_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int stall_cycles = 0;

   ps2_mouse_packet_tracker i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_cursor_x         (rsp_cursor_x),
      .rsp_cursor_y         (rsp_cursor_y),
      .rsp_left_button      (rsp_left_button),
      .rsp_middle_button    (rsp_middle_button),
      .rsp_right_button     (rsp_right_button),
      .rsp_overflow_dropped (rsp_overflow_dropped),
      .rsp_sync_bit_missing (rsp_sync_bit_missing)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      packet_report_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.cursor_x         = rsp_cursor_x;
         got.cursor_y         = rsp_cursor_y;
         got.left_button      = rsp_left_button;
         got.middle_button    = rsp_middle_button;
         got.right_button     = rsp_right_button;
         got.overflow_dropped = rsp_overflow_dropped;
         got.sync_bit_missing = rsp_sync_bit_missing;
         sb.check_packet_report(got);
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("ps2_mouse_packet_tracker: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_byte(byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.take_byte(value);
      bytes_sent++;
   endtask

   task automatic send_three(byte_type hdr, byte_type dx, byte_type dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   task automatic send_packet(int x_neg_pct, int y_neg_pct);
      byte_type hdr;
      int       n_bytes;
      hdr = byte_type'($urandom_range(7));
      hdr[HDR_SYNC]   = ($urandom_range(99) >= 6);
      hdr[HDR_X_SIGN] = ($urandom_range(99) < x_neg_pct);
      hdr[HDR_Y_SIGN] = ($urandom_range(99) < y_neg_pct);
      hdr[HDR_X_OVF]  = ($urandom_range(99) < 6);
      hdr[HDR_Y_OVF]  = ($urandom_range(99) < 6);
      n_bytes = sb.four_byte_reg ? 4 : 3;
      // now and then a stray byte ahead of the packet, or a packet cut short
      if ($urandom_range(99) < 5)
         send_byte(byte_type'($urandom));
      if ($urandom_range(99) < 5)
         n_bytes = $urandom_range(1, n_bytes - 1);
      send_byte(hdr);
      for (int i = 1; i < n_bytes; i++)
         send_byte(byte_type'($urandom));
   endtask

   task automatic set_screen(size_type w, size_type h, logic four);
      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0)
         @(posedge clock);
      // a byte that closes no packet may still be in flight
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCREEN_WIDTH;
      csr_wdata        <= w;
      @(posedge clock);
      sb.write_reg(CSR_SCREEN_WIDTH, w);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(CSR_SCREEN_HEIGHT, h);
      csr_index <= CSR_FOUR_BYTE;
      csr_wdata <= size_type'(four);
      @(posedge clock);
      sb.write_reg(CSR_FOUR_BYTE, size_type'(four));
      csr_write_enable <= 1'b0;
   endtask

   function automatic size_type pick_screen_size();
      case ($urandom_range(9))
         0:       return size_type'(0);
         1:       return size_type'(1);
         2:       return size_type'($urandom_range(2, 16));
         3:       return size_type'(4096);
         4:       return size_type'($urandom_range(4097, 8191));
         5:       return size_type'(8191);
         6, 7:    return size_type'($urandom_range(17, 1024));
         default: return size_type'($urandom_range(1025, 4095));
      endcase
   endfunction

   function automatic int pick_bias();
      case ($urandom_range(2))
         0:       return 5;
         1:       return 50;
         default: return 95;
      endcase
   endfunction

   initial begin
      int regime;
      int phase;
      int n_pkts;
      int x_bias;
      int y_bias;
      int stop_at;
      int directed_bytes;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sign extremes, clamping at zero, missing sync, overflow
      send_three(8'h2F, 8'h7F, 8'h80);
      send_three(8'h18, 8'h00, 8'hFF);
      send_three(8'h00, 8'hFF, 8'h00);
      send_three(8'hFF, 8'hFF, 8'hFF);
      send_three(8'h48, 8'h10, 8'h10);
      send_three(8'h88, 8'h10, 8'h10);
      send_three(8'h30, 8'h00, 8'h00);
      // packet length drops from four to three with the last slot pending
      set_screen(WIDTH_RESET, HEIGHT_RESET, 1'b1);
      send_three(8'h09, 8'h01, 8'h01);
      set_screen(WIDTH_RESET, HEIGHT_RESET, 1'b0);
      send_byte(8'hAA);
      directed_bytes = bytes_sent;

      phase = 0;
      for (regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         stop_at = directed_bytes + (regime + 1) * RANDOM_BYTES / 3;
         while (bytes_sent < stop_at) begin
            case (phase)
               0:       set_screen(size_type'(1), size_type'(1), 1'b0);
               1:       set_screen(size_type'(8191), size_type'(8191), 1'b1);
               2:       set_screen(size_type'(0), size_type'(0), 1'b0);
               3:       set_screen(size_type'(4096), size_type'(4096), 1'b1);
               4:       set_screen(size_type'(1), size_type'(4096), 1'b0);
               default: set_screen(pick_screen_size(), pick_screen_size(),
                                   logic'($urandom_range(1)));
            endcase
            phase++;
            x_bias = pick_bias();
            y_bias = pick_bias();
            n_pkts = $urandom_range(3, 20);
            for (int p = 0; p < n_pkts; p++)
               send_packet(x_bias, y_bias);
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("ps2_mouse_packet_tracker: match");
      else
         $display("ps2_mouse_packet_tracker: mismatch");
      $finish;
   end

endmodule

### ps2_mouse_packet_tracker.f
hw/rtl/ps2mpt_pkg.sv
hw/rtl/ps2_mouse_packet_tracker.sv
verif/tb_ps2_mouse_packet_tracker.sv
